// ===== sv/tpds_pkg.sv =====
// shared constants, types and sine table builder for the docking sequencer
package tpds_pkg;

   // field widths
   localparam int CMD_W       = 2;
   localparam int ANGLE_W     = 16;
   localparam int MODE_W      = 3;
   localparam int SPEED_W     = 16;
   localparam int GAIN_W      = 16;
   localparam int LIMIT_W     = 15;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int SINE_W      = 16;

   // command codes
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

   // docking modes
   localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_APPROACH = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TOUCHING = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ON       = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DOCKED   = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TILT_GAIN      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_APPROACH_SPEED = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIMB_SPEED    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOUCH_ANGLE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ON_ANGLE       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_TOL      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_POSITIVE_SIDE  = 3'd6;

   // register reset values
   localparam logic [GAIN_W-1:0]  RST_TILT_GAIN      = 16'd256;
   localparam logic [LIMIT_W-1:0] RST_APPROACH_SPEED = 15'd2048;
   localparam logic [LIMIT_W-1:0] RST_CLIMB_SPEED    = 15'd6144;
   localparam logic [LIMIT_W-1:0] RST_TOUCH_ANGLE    = 15'd1638;
   localparam logic [LIMIT_W-1:0] RST_ON_ANGLE       = 15'd2048;
   localparam logic [LIMIT_W-1:0] RST_LEVEL_TOL      = 15'd410;

   // sine table geometry
   localparam int SINE_TABLE_ENTRIES = 1024;
   localparam int SINE_IDX_W         = $clog2(SINE_TABLE_ENTRIES);

   // yaw to table phase: yaw * entries * round(2^32 / 2pi), units of 2^-45 steps
   localparam longint unsigned INV_TWO_PI_Q32 = 64'd683565276;
   localparam longint unsigned PHASE_K =
      INV_TWO_PI_Q32 * longint'(SINE_TABLE_ENTRIES);
   localparam int PHASE_K_W   = $clog2(PHASE_K + 64'd1);
   localparam int ACC_W       = (PHASE_K_W + 2 > 20) ? PHASE_K_W + 2 : 20;
   // accumulator holds the product shifted down by the 16 multiplier bits
   localparam int PHASE_SHIFT = 45 - ANGLE_W;
   localparam int QUOT_W      = ACC_W - PHASE_SHIFT;
   // half-step rounding, and a quarter turn on top of it for the cosine
   localparam longint unsigned SIN_BIAS = 64'd1 << (44 - ANGLE_W);
   localparam longint unsigned COS_BIAS =
      (longint'(SINE_TABLE_ENTRIES) << (43 - ANGLE_W)) + SIN_BIAS;

   // Q30 angles for the table build
   localparam longint unsigned PI_Q30      = 64'd3373259426;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;

   typedef longint unsigned taylor_div_type [6];
   localparam taylor_div_type TAYLOR_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

   typedef logic signed [SINE_W-1:0] sine_tab_type [SINE_TABLE_ENTRIES];

   // first quadrant sine of a Q30 angle, Q14 result
   function automatic logic [SINE_W-1:0] quarter_sine(longint unsigned a);
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          r;
      x2   = (a * a) >> 30;
      term = a;
      sum  = longint'(a);
      for (int i = 0; i < 6; i++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[i];
         if (i[0] == 1'b0) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = (sum + 64'sd32768) >>> 16;
      if (r > 64'sd16384) begin
         r = 64'sd16384;
      end
      return SINE_W'(r);
   endfunction

   // full turn built from the first quadrant
   function automatic sine_tab_type build_sine_tab();
      sine_tab_type      tab;
      longint unsigned   a;
      logic              neg;
      logic [SINE_W-1:0] v;
      for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
         a   = longint'(k) * TWO_PI_Q30 / SINE_TABLE_ENTRIES;
         neg = 1'b0;
         if (a >= PI_Q30) begin
            a   = a - PI_Q30;
            neg = 1'b1;
         end
         if (a > HALF_PI_Q30) begin
            a = PI_Q30 - a;
         end
         v      = quarter_sine(a);
         tab[k] = neg ? -$signed(v) : $signed(v);
      end
      return tab;
   endfunction

endpackage

// ===== sv/tpds_req_if.sv =====
// request channel: command and orientation
interface tpds_req_if;
   logic                                  valid;
   logic                                  ready;
   logic        [tpds_pkg::CMD_W-1:0]     command;
   logic signed [tpds_pkg::ANGLE_W-1:0]   roll;
   logic signed [tpds_pkg::ANGLE_W-1:0]   pitch;
   logic signed [tpds_pkg::ANGLE_W-1:0]   yaw;

   modport source (output valid, command, roll, pitch, yaw, input ready);
   modport sink (input valid, command, roll, pitch, yaw, output ready);
endinterface

// ===== sv/tpds_rsp_if.sv =====
// response channel: mode and drive speed
interface tpds_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic        [tpds_pkg::MODE_W-1:0]    mode;
   logic signed [tpds_pkg::SPEED_W-1:0]   drive_speed;
   logic                                  started;

   modport source (output valid, mode, drive_speed, started, input ready);
   modport sink (input valid, mode, drive_speed, started, output ready);
endinterface

// ===== sv/tpds_sine_rom.sv =====
// sine lookup rom, one registered read port
module tpds_sine_rom (
   input  logic                                clock,
   input  logic        [tpds_pkg::SINE_IDX_W-1:0] rd_addr,
   output logic signed [tpds_pkg::SINE_W-1:0]     rd_data
);

   localparam tpds_pkg::sine_tab_type SINE_TAB = tpds_pkg::build_sine_tab();

   logic signed [tpds_pkg::SINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= SINE_TAB[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tilt_platform_docking_sequencer_unit.sv =====
// top level of the tilt platform docking sequencer
//
//   channel   dir   handshake          contents
//   req_ch    in    valid / ready      command, roll, pitch, yaw
//   rsp_ch    out   valid / ready      mode, drive_speed, started
//   csr_*     in    csr_we only        csr_index, csr_wdata (write only)
//
// a tick runs the phase, sine, cosine, tilt load, tilt and eval states, then gain when the
// mode is on platform, then fin; start, reset and unused commands go straight to fin
// a tick uses one shared bit-serial multiply-accumulate unit:
// 16 steps for the yaw phase, 16 for pitch*sin - roll*cos, 16 for the gain
// the sine and cosine come from one rom port, one read each
// reset is synchronous and returns the mode to idle and the speed to zero
// a full response register lets the next transaction in; a transaction
// waits in its last state only when the response register is still full
module tilt_platform_docking_sequencer_unit (
   input  logic                                clock,
   input  logic                                reset,
   tpds_req_if.sink                            req_ch,
   tpds_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [tpds_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tpds_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int ACC_W  = tpds_pkg::ACC_W;
   localparam int QUOT_W = tpds_pkg::QUOT_W;
   localparam int IDX_W  = tpds_pkg::SINE_IDX_W;
   localparam int ANG_W  = tpds_pkg::ANGLE_W;
   localparam int BAL_W  = 26;

   // sequencer states
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_PHASE     = 4'd1;
   localparam logic [3:0] ST_SINE      = 4'd2;
   localparam logic [3:0] ST_COSINE    = 4'd3;
   localparam logic [3:0] ST_TILT_LOAD = 4'd4;
   localparam logic [3:0] ST_TILT      = 4'd5;
   localparam logic [3:0] ST_EVAL      = 4'd6;
   localparam logic [3:0] ST_GAIN      = 4'd7;
   localparam logic [3:0] ST_FIN       = 4'd8;

   localparam logic [3:0] MUL_LAST = 4'(ANG_W - 1);

   // configuration registers
   logic [tpds_pkg::GAIN_W-1:0]  tilt_gain_ff;
   logic [tpds_pkg::LIMIT_W-1:0] approach_speed_ff;
   logic [tpds_pkg::LIMIT_W-1:0] climb_speed_ff;
   logic [tpds_pkg::LIMIT_W-1:0] touch_angle_ff;
   logic [tpds_pkg::LIMIT_W-1:0] on_angle_ff;
   logic [tpds_pkg::LIMIT_W-1:0] level_tol_ff;
   logic                         positive_side_ff;

   // control state
   logic [3:0]                          state_ff, state_in;
   logic [3:0]                          cnt_ff, cnt_in;
   logic [tpds_pkg::MODE_W-1:0]         mode_ff, mode_in;
   logic signed [tpds_pkg::SPEED_W-1:0] held_ff, held_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   // payload
   logic [tpds_pkg::CMD_W-1:0]           cmd_ff, cmd_in;
   logic signed [ANG_W-1:0]              roll_ff, roll_in;
   logic signed [ANG_W-1:0]              pitch_ff, pitch_in;
   logic [ANG_W-1:0]                     m1_ff, m1_in;
   logic [ANG_W-1:0]                     m2_ff, m2_in;
   logic                                 m1_signed_ff, m1_signed_in;
   logic signed [ACC_W-1:0]              acc_hi_ff, acc_hi_in;
   logic [ANG_W-1:0]                     acc_lo_ff, acc_lo_in;
   logic signed [ACC_W-1:0]              op_a_ff, op_a_in;
   logic signed [tpds_pkg::SINE_W-1:0]   op_b_ff, op_b_in;
   logic [16:0]                          mag_ff, mag_in;
   logic [tpds_pkg::MODE_W-1:0]          rsp_mode_ff, rsp_mode_in;
   logic signed [tpds_pkg::SPEED_W-1:0]  rsp_speed_ff, rsp_speed_in;
   logic                                 rsp_started_ff, rsp_started_in;

   // serial step
   logic                    step_last;
   logic signed [ACC_W-1:0] add_a;
   logic signed [ACC_W-1:0] sub_b;
   logic signed [ACC_W-1:0] step_sum;

   // table index
   logic signed [ACC_W-1:0]  sin_sum;
   logic signed [ACC_W-1:0]  cos_sum;
   logic signed [QUOT_W-1:0] sin_q;
   logic signed [QUOT_W-1:0] cos_q;
   logic [IDX_W-1:0]         rom_addr;
   logic signed [tpds_pkg::SINE_W-1:0] rom_data;

   // tilt and speed
   logic signed [32:0] tilt_sum;
   logic signed [18:0] tilt;
   logic signed [18:0] tilt_abs;
   logic [34:0]        bal_sum;
   logic [BAL_W-1:0]   bal_mag;

   // response values
   logic                                fin_go;
   logic [tpds_pkg::MODE_W-1:0]         fin_mode;
   logic signed [tpds_pkg::SPEED_W-1:0] fin_held;

   // map a floored table position into the table, at most one turn off
   function automatic logic [IDX_W-1:0] wrap_index(logic signed [QUOT_W-1:0] q);
      logic signed [QUOT_W-1:0] n;
      logic signed [QUOT_W-1:0] w;
      n = QUOT_W'(tpds_pkg::SINE_TABLE_ENTRIES);
      if (q < 0) begin
         w = q + n;
      end else if (q >= n) begin
         w = q - n;
      end else begin
         w = q;
      end
      return w[IDX_W-1:0];
   endfunction

   // side sign and saturation to the speed range
   function automatic logic signed [tpds_pkg::SPEED_W-1:0] side_speed(
      logic [BAL_W-1:0] m, logic pos);
      logic signed [tpds_pkg::SPEED_W-1:0] s;
      if (pos) begin
         s = (m > BAL_W'(32767)) ? 16'sh7fff : $signed(m[15:0]);
      end else begin
         s = (m > BAL_W'(32768)) ? 16'sh8000 : $signed(16'(~m[15:0] + 16'd1));
      end
      return s;
   endfunction

   tpds_sine_rom u_sine_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   // one multiplier bit of each operand per cycle, lsb first; the sign bit
   // of a signed multiplier weighs negative
   assign step_last = (cnt_ff == MUL_LAST);

   always_comb begin
      add_a = m1_ff[0] ? op_a_ff : '0;
      if (step_last && m1_signed_ff) begin
         add_a = -add_a;
      end
      sub_b = m2_ff[0] ? ACC_W'(op_b_ff) : '0;
      if (step_last) begin
         sub_b = -sub_b;
      end
      step_sum = acc_hi_ff + add_a - sub_b;
   end

   // table positions from the yaw phase, floored after the rounding bias
   assign sin_sum  = acc_hi_ff + $signed(ACC_W'(tpds_pkg::SIN_BIAS));
   assign cos_sum  = acc_hi_ff + $signed(ACC_W'(tpds_pkg::COS_BIAS));
   assign sin_q    = sin_sum[ACC_W-1:tpds_pkg::PHASE_SHIFT];
   assign cos_q    = cos_sum[ACC_W-1:tpds_pkg::PHASE_SHIFT];
   assign rom_addr = (state_ff == ST_SINE) ? wrap_index(sin_q) : wrap_index(cos_q);

   // tilt rounded from Q.27 to Q5.13
   assign tilt_sum = $signed({acc_hi_ff[16:0], acc_lo_ff}) + 33'sd8192;
   assign tilt     = tilt_sum[32:14];
   assign tilt_abs = tilt[18] ? -tilt : tilt;

   // balancing speed, gain * |tilt| rounded to units of 1/4096
   assign bal_sum = {acc_hi_ff[18:0], acc_lo_ff} + 35'd256;
   assign bal_mag = bal_sum[34:9];

   // mode step and held speed for the finished transaction
   always_comb begin
      fin_mode = mode_ff;
      fin_held = held_ff;
      case (cmd_ff)
         tpds_pkg::CMD_TICK: begin
            case (mode_ff)
               tpds_pkg::MODE_APPROACH: begin
                  fin_held = side_speed(BAL_W'(approach_speed_ff), positive_side_ff);
                  if (mag_ff > 17'(touch_angle_ff)) begin
                     fin_mode = tpds_pkg::MODE_TOUCHING;
                  end
               end
               tpds_pkg::MODE_TOUCHING: begin
                  fin_held = side_speed(BAL_W'(climb_speed_ff), positive_side_ff);
                  if (mag_ff > 17'(on_angle_ff)) begin
                     fin_mode = tpds_pkg::MODE_ON;
                  end
               end
               tpds_pkg::MODE_ON: begin
                  fin_held = side_speed(bal_mag, positive_side_ff);
                  if (mag_ff < 17'(level_tol_ff)) begin
                     fin_mode = tpds_pkg::MODE_DOCKED;
                  end
               end
               default: begin
                  fin_held = '0;
               end
            endcase
         end
         tpds_pkg::CMD_START: begin
            if (mode_ff == tpds_pkg::MODE_IDLE) begin
               fin_mode = tpds_pkg::MODE_APPROACH;
            end
         end
         tpds_pkg::CMD_RESET: begin
            fin_mode = tpds_pkg::MODE_IDLE;
         end
         default: begin
         end
      endcase
   end

   assign fin_go = !rsp_valid_ff || rsp_ch.ready;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      mode_in        = mode_ff;
      held_in        = held_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      cmd_in         = cmd_ff;
      roll_in        = roll_ff;
      pitch_in       = pitch_ff;
      m1_in          = m1_ff;
      m2_in          = m2_ff;
      m1_signed_in   = m1_signed_ff;
      acc_hi_in      = acc_hi_ff;
      acc_lo_in      = acc_lo_ff;
      op_a_in        = op_a_ff;
      op_b_in        = op_b_ff;
      mag_in         = mag_ff;
      rsp_mode_in    = rsp_mode_ff;
      rsp_speed_in   = rsp_speed_ff;
      rsp_started_in = rsp_started_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               cmd_in   = req_ch.command;
               roll_in  = req_ch.roll;
               pitch_in = req_ch.pitch;
               if (req_ch.command == tpds_pkg::CMD_TICK) begin
                  // yaw times the phase constant
                  m1_in        = req_ch.yaw;
                  m2_in        = '0;
                  m1_signed_in = 1'b1;
                  op_a_in      = $signed(ACC_W'(tpds_pkg::PHASE_K));
                  acc_hi_in    = '0;
                  acc_lo_in    = '0;
                  cnt_in       = '0;
                  state_in     = ST_PHASE;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_PHASE, ST_TILT, ST_GAIN: begin
            acc_hi_in = step_sum >>> 1;
            acc_lo_in = {step_sum[0], acc_lo_ff[ANG_W-1:1]};
            m1_in     = m1_ff >> 1;
            m2_in     = m2_ff >> 1;
            cnt_in    = cnt_ff + 4'd1;
            if (step_last) begin
               unique case (state_ff)
                  ST_PHASE: state_in = ST_SINE;
                  ST_TILT:  state_in = ST_EVAL;
                  default:  state_in = ST_FIN;
               endcase
            end
         end
         ST_SINE: begin
            state_in = ST_COSINE;
         end
         ST_COSINE: begin
            // sine word is out of the rom
            op_a_in  = ACC_W'(rom_data);
            state_in = ST_TILT_LOAD;
         end
         ST_TILT_LOAD: begin
            // pitch*sin - roll*cos
            op_b_in      = rom_data;
            m1_in        = pitch_ff;
            m2_in        = roll_ff;
            m1_signed_in = 1'b1;
            acc_hi_in    = '0;
            acc_lo_in    = '0;
            cnt_in       = '0;
            state_in     = ST_TILT;
         end
         ST_EVAL: begin
            mag_in = tilt_abs[16:0];
            if (mode_ff == tpds_pkg::MODE_ON) begin
               m1_in        = tilt_gain_ff;
               m2_in        = '0;
               m1_signed_in = 1'b0;
               op_a_in      = $signed(ACC_W'(tilt_abs[16:0]));
               acc_hi_in    = '0;
               acc_lo_in    = '0;
               cnt_in       = '0;
               state_in     = ST_GAIN;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (fin_go) begin
               mode_in        = fin_mode;
               held_in        = fin_held;
               rsp_valid_in   = 1'b1;
               rsp_mode_in    = fin_mode;
               rsp_started_in = (fin_mode != tpds_pkg::MODE_IDLE);
               if (fin_mode == tpds_pkg::MODE_IDLE || fin_mode == tpds_pkg::MODE_DOCKED) begin
                  rsp_speed_in = '0;
               end else begin
                  rsp_speed_in = fin_held;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         mode_ff      <= tpds_pkg::MODE_IDLE;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         mode_ff      <= mode_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration writes, masked to the register width
   always_ff @(posedge clock) begin
      if (reset) begin
         tilt_gain_ff      <= tpds_pkg::RST_TILT_GAIN;
         approach_speed_ff <= tpds_pkg::RST_APPROACH_SPEED;
         climb_speed_ff    <= tpds_pkg::RST_CLIMB_SPEED;
         touch_angle_ff    <= tpds_pkg::RST_TOUCH_ANGLE;
         on_angle_ff       <= tpds_pkg::RST_ON_ANGLE;
         level_tol_ff      <= tpds_pkg::RST_LEVEL_TOL;
         positive_side_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            tpds_pkg::CSR_TILT_GAIN:      tilt_gain_ff      <= csr_wdata;
            tpds_pkg::CSR_APPROACH_SPEED: approach_speed_ff <= csr_wdata[14:0];
            tpds_pkg::CSR_CLIMB_SPEED:    climb_speed_ff    <= csr_wdata[14:0];
            tpds_pkg::CSR_TOUCH_ANGLE:    touch_angle_ff    <= csr_wdata[14:0];
            tpds_pkg::CSR_ON_ANGLE:       on_angle_ff       <= csr_wdata[14:0];
            tpds_pkg::CSR_LEVEL_TOL:      level_tol_ff      <= csr_wdata[14:0];
            tpds_pkg::CSR_POSITIVE_SIDE:  positive_side_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      roll_ff        <= roll_in;
      pitch_ff       <= pitch_in;
      m1_ff          <= m1_in;
      m2_ff          <= m2_in;
      m1_signed_ff   <= m1_signed_in;
      acc_hi_ff      <= acc_hi_in;
      acc_lo_ff      <= acc_lo_in;
      op_a_ff        <= op_a_in;
      op_b_ff        <= op_b_in;
      mag_ff         <= mag_in;
      rsp_mode_ff    <= rsp_mode_in;
      rsp_speed_ff   <= rsp_speed_in;
      rsp_started_ff <= rsp_started_in;
   end

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.mode        = rsp_mode_ff;
   assign rsp_ch.drive_speed = rsp_speed_ff;
   assign rsp_ch.started     = rsp_started_ff;

endmodule

// ===== sim/tb_tilt_platform_docking_sequencer_unit.sv =====
// testbench for the tilt platform docking sequencer: directed and random transactions
`timescale 1ns / 100ps

module tb_tilt_platform_docking_sequencer_unit;

   // command code with no meaning, the block must ignore it
   localparam logic [tpds_pkg::CMD_W-1:0]       CMD_UNUSED       = 2'd3;
   // register index with no register behind it
   localparam logic [tpds_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   // fixed point constants of the tilt math, Q30 angles and yaw-to-phase scale
   localparam longint unsigned Q30_PI      = 64'd3373259426;
   localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
   localparam longint unsigned Q30_TWO_PI  = 64'd6746518852;
   localparam longint          PHASE_PER_YAW =
      64'sd683565276 * longint'(tpds_pkg::SINE_TABLE_ENTRIES);
   localparam longint          QUARTER_TURN =
      longint'(tpds_pkg::SINE_TABLE_ENTRIES) <<< 43;

   localparam int SETTLE_CYCLES  = 80;      // longer than the longest tick
   localparam int STALL_CYCLES   = 400;     // long receiver hold-off
   localparam int CHUNK_ITEMS    = 250;
   localparam int NUM_CHUNKS     = 6;
   localparam int RUN_LIMIT_NS   = 1_500_000;

   typedef struct packed {
      logic        [tpds_pkg::CMD_W-1:0]   command;
      logic signed [tpds_pkg::ANGLE_W-1:0] roll;
      logic signed [tpds_pkg::ANGLE_W-1:0] pitch;
      logic signed [tpds_pkg::ANGLE_W-1:0] yaw;
   } orient_cmd_type;

   typedef struct packed {
      logic        [tpds_pkg::MODE_W-1:0]  mode;
      logic signed [tpds_pkg::SPEED_W-1:0] drive_speed;
      logic                                started;
   } dock_status_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_we;
   logic [tpds_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [tpds_pkg::CSR_DATA_W-1:0]  csr_wdata;

   tpds_req_if req_ch ();
   tpds_rsp_if rsp_ch ();

   tilt_platform_docking_sequencer_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // commands waiting to go out, status values waiting to come back
   orient_cmd_type  pending_cmd_q [$];
   dock_status_type expected_status_q [$];

   int queued_count;
   int accepted_count;
   int mismatch_count;
   int req_gap_pct;
   int rsp_stall_pct;

   // receiver hold-off, counted in its own process
   logic stall_request;
   logic stall_taken;
   int   stall_left;

   // predictor copy of the sine table, registers and sequencer state
   logic signed [tpds_pkg::SINE_W-1:0]  sine_q14_rom [tpds_pkg::SINE_TABLE_ENTRIES];
   logic [tpds_pkg::GAIN_W-1:0]         gain_cfg;
   logic [tpds_pkg::LIMIT_W-1:0]        approach_cfg;
   logic [tpds_pkg::LIMIT_W-1:0]        climb_cfg;
   logic [tpds_pkg::LIMIT_W-1:0]        touch_cfg;
   logic [tpds_pkg::LIMIT_W-1:0]        on_cfg;
   logic [tpds_pkg::LIMIT_W-1:0]        level_cfg;
   logic                                side_cfg;
   logic [tpds_pkg::MODE_W-1:0]         dock_mode;
   logic signed [tpds_pkg::SPEED_W-1:0] held_speed;

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // first quadrant sine, Taylor series to x^13 in Q30, rounded to Q14
   function automatic logic signed [tpds_pkg::SINE_W-1:0] q14_quarter_sine(
      longint unsigned a);
      longint unsigned x2;
      longint unsigned term;
      longint unsigned divisor;
      longint          sum;
      longint          r;
      x2   = (a * a) >> 30;
      term = a;
      sum  = longint'(a);
      for (int i = 1; i <= 6; i++) begin
         divisor = longint'((2 * i) * (2 * i + 1));
         term    = ((term * x2) >> 30) / divisor;
         if (i % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = (sum + 32768) / 65536;
      if (r > 16384) begin
         r = 16384;
      end
      return tpds_pkg::SINE_W'(r);
   endfunction

   // full turn by quarter-wave symmetry
   function automatic void fill_sine_rom();
      longint unsigned                    a;
      logic                               neg;
      logic signed [tpds_pkg::SINE_W-1:0] v;
      for (int k = 0; k < tpds_pkg::SINE_TABLE_ENTRIES; k++) begin
         a   = longint'(k) * Q30_TWO_PI / tpds_pkg::SINE_TABLE_ENTRIES;
         neg = 1'b0;
         if (a >= Q30_PI) begin
            a   = a - Q30_PI;
            neg = 1'b1;
         end
         if (a > Q30_HALF_PI) begin
            a = Q30_PI - a;
         end
         v               = q14_quarter_sine(a);
         sine_q14_rom[k] = neg ? -v : v;
      end
   endfunction

   // phase in 2^-45 table steps, nearest entry with halves rounding up
   function automatic logic signed [tpds_pkg::SINE_W-1:0] rom_at_phase(longint phase);
      longint          biased;
      longint unsigned step;
      biased = phase + (longint'(tpds_pkg::SINE_TABLE_ENTRIES) <<< 46) + (64'sd1 <<< 44);
      step   = longint'(biased) >> 45;
      return sine_q14_rom[step % tpds_pkg::SINE_TABLE_ENTRIES];
   endfunction

   // sign by platform side, then clamp to the speed range
   function automatic logic signed [tpds_pkg::SPEED_W-1:0] sided_speed(longint magnitude);
      longint v;
      v = side_cfg ? magnitude : -magnitude;
      if (v > 32767) begin
         v = 32767;
      end else if (v < -32768) begin
         v = -32768;
      end
      return tpds_pkg::SPEED_W'(v);
   endfunction

   // advance the docking sequence by one command and queue its status
   function automatic void predict_docking_step(orient_cmd_type cmd);
      longint                             phase;
      longint                             prod;
      longint                             tilt;
      longint                             mag;
      logic signed [tpds_pkg::SINE_W-1:0] s_val;
      logic signed [tpds_pkg::SINE_W-1:0] c_val;
      dock_status_type                    st;
      case (cmd.command)
         tpds_pkg::CMD_TICK: begin
            phase = longint'(cmd.yaw) * PHASE_PER_YAW;
            s_val = rom_at_phase(phase);
            c_val = rom_at_phase(phase + QUARTER_TURN);
            prod  = longint'(cmd.pitch) * longint'(s_val)
                  - longint'(cmd.roll) * longint'(c_val);
            tilt  = (prod + 64'sd8192) >>> 14;
            mag   = (tilt < 0) ? -tilt : tilt;
            // speed comes from the mode held before the tick
            case (dock_mode)
               tpds_pkg::MODE_APPROACH: begin
                  if (mag > longint'(touch_cfg)) begin
                     dock_mode = tpds_pkg::MODE_TOUCHING;
                  end
                  held_speed = sided_speed(longint'(approach_cfg));
               end
               tpds_pkg::MODE_TOUCHING: begin
                  if (mag > longint'(on_cfg)) begin
                     dock_mode = tpds_pkg::MODE_ON;
                  end
                  held_speed = sided_speed(longint'(climb_cfg));
               end
               tpds_pkg::MODE_ON: begin
                  if (mag < longint'(level_cfg)) begin
                     dock_mode = tpds_pkg::MODE_DOCKED;
                  end
                  held_speed = sided_speed((longint'(gain_cfg) * mag + 256) >>> 9);
               end
               default: begin
                  held_speed = '0;
               end
            endcase
         end
         tpds_pkg::CMD_START: begin
            if (dock_mode == tpds_pkg::MODE_IDLE) begin
               dock_mode = tpds_pkg::MODE_APPROACH;
            end
         end
         tpds_pkg::CMD_RESET: begin
            dock_mode = tpds_pkg::MODE_IDLE;
         end
         default: begin
         end
      endcase
      st.mode        = dock_mode;
      st.drive_speed = (dock_mode == tpds_pkg::MODE_IDLE ||
                        dock_mode == tpds_pkg::MODE_DOCKED) ? '0 : held_speed;
      st.started     = (dock_mode != tpds_pkg::MODE_IDLE);
      expected_status_q.push_back(st);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s at %0t: got %0d expected %0d", what, $time, got, want);
      mismatch_count++;
   endtask

   task automatic queue_cmd(logic [tpds_pkg::CMD_W-1:0] c, int r, int p, int y);
      orient_cmd_type item;
      item.command = c;
      item.roll    = tpds_pkg::ANGLE_W'(r);
      item.pitch   = tpds_pkg::ANGLE_W'(p);
      item.yaw     = tpds_pkg::ANGLE_W'(y);
      pending_cmd_q.push_back(item);
      queued_count++;
   endtask

   // tick with a tilt size class: full range down to near level
   task automatic queue_random_tick();
      int amp;
      case ($urandom_range(3, 0))
         0:       amp = 0;
         1:       amp = 4095;
         2:       amp = 1023;
         default: amp = 255;
      endcase
      if (amp == 0) begin
         queue_cmd(tpds_pkg::CMD_TICK, $urandom_range(65535, 0), $urandom_range(65535, 0),
                   $urandom_range(65535, 0));
      end else begin
         queue_cmd(tpds_pkg::CMD_TICK, $urandom_range(2 * amp, 0) - amp,
                   $urandom_range(2 * amp, 0) - amp, $urandom_range(65535, 0));
      end
   endtask

   // mostly docking runs (start then ticks), some loose ticks and noise
   task automatic queue_docking_traffic(int count);
      int goal;
      int pick;
      goal = queued_count + count;
      while (queued_count < goal) begin
         pick = $urandom_range(99, 0);
         if (pick < 80) begin
            queue_cmd(tpds_pkg::CMD_START, 0, 0, 0);
            repeat ($urandom_range(14, 2)) queue_random_tick();
            if ($urandom_range(9, 0) < 7) begin
               queue_cmd(tpds_pkg::CMD_RESET, $urandom_range(65535, 0), 0, 0);
            end
         end else if (pick < 90) begin
            queue_random_tick();
         end else begin
            queue_cmd(tpds_pkg::CMD_W'($urandom_range(3, 0)), $urandom_range(65535, 0),
                      $urandom_range(65535, 0), $urandom_range(65535, 0));
         end
      end
   endtask

   task automatic write_csr(logic [tpds_pkg::CSR_INDEX_W-1:0] idx,
                            logic [tpds_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         tpds_pkg::CSR_TILT_GAIN:      gain_cfg     = data;
         tpds_pkg::CSR_APPROACH_SPEED: approach_cfg = data[tpds_pkg::LIMIT_W-1:0];
         tpds_pkg::CSR_CLIMB_SPEED:    climb_cfg    = data[tpds_pkg::LIMIT_W-1:0];
         tpds_pkg::CSR_TOUCH_ANGLE:    touch_cfg    = data[tpds_pkg::LIMIT_W-1:0];
         tpds_pkg::CSR_ON_ANGLE:       on_cfg       = data[tpds_pkg::LIMIT_W-1:0];
         tpds_pkg::CSR_LEVEL_TOL:      level_cfg    = data[tpds_pkg::LIMIT_W-1:0];
         tpds_pkg::CSR_POSITIVE_SIDE:  side_cfg     = data[0];
         default: begin
         end
      endcase
   endtask

   // register sets: reset values, all max (negative side), all zero (positive side), then random
   task automatic apply_settings(int which);
      logic [tpds_pkg::LIMIT_W-1:0] touch;
      case (which)
         0: begin
            write_csr(tpds_pkg::CSR_TILT_GAIN, tpds_pkg::RST_TILT_GAIN);
            write_csr(tpds_pkg::CSR_APPROACH_SPEED, 16'(tpds_pkg::RST_APPROACH_SPEED));
            write_csr(tpds_pkg::CSR_CLIMB_SPEED, 16'(tpds_pkg::RST_CLIMB_SPEED));
            write_csr(tpds_pkg::CSR_TOUCH_ANGLE, 16'(tpds_pkg::RST_TOUCH_ANGLE));
            write_csr(tpds_pkg::CSR_ON_ANGLE, 16'(tpds_pkg::RST_ON_ANGLE));
            write_csr(tpds_pkg::CSR_LEVEL_TOL, 16'(tpds_pkg::RST_LEVEL_TOL));
            write_csr(tpds_pkg::CSR_POSITIVE_SIDE, 16'd1);
         end
         1: begin
            write_csr(tpds_pkg::CSR_TILT_GAIN, 16'hffff);
            write_csr(tpds_pkg::CSR_APPROACH_SPEED, 16'h7fff);
            write_csr(tpds_pkg::CSR_CLIMB_SPEED, 16'h7fff);
            write_csr(tpds_pkg::CSR_TOUCH_ANGLE, 16'h7fff);
            write_csr(tpds_pkg::CSR_ON_ANGLE, 16'h7fff);
            write_csr(tpds_pkg::CSR_LEVEL_TOL, 16'h7fff);
            write_csr(tpds_pkg::CSR_POSITIVE_SIDE, 16'd0);
         end
         2: begin
            write_csr(tpds_pkg::CSR_TILT_GAIN, 16'd0);
            write_csr(tpds_pkg::CSR_APPROACH_SPEED, 16'd0);
            write_csr(tpds_pkg::CSR_CLIMB_SPEED, 16'd0);
            write_csr(tpds_pkg::CSR_TOUCH_ANGLE, 16'd0);
            write_csr(tpds_pkg::CSR_ON_ANGLE, 16'd0);
            write_csr(tpds_pkg::CSR_LEVEL_TOL, 16'd0);
            write_csr(tpds_pkg::CSR_POSITIVE_SIDE, 16'd1);
         end
         default: begin
            // upper data bits random to check the width masking
            touch = tpds_pkg::LIMIT_W'($urandom_range(3000, 0));
            write_csr(tpds_pkg::CSR_TILT_GAIN, 16'($urandom_range(65535, 0)));
            write_csr(tpds_pkg::CSR_APPROACH_SPEED, 16'($urandom_range(65535, 0)));
            write_csr(tpds_pkg::CSR_CLIMB_SPEED, 16'($urandom_range(65535, 0)));
            write_csr(tpds_pkg::CSR_TOUCH_ANGLE, {1'($urandom_range(1, 0)), touch});
            write_csr(tpds_pkg::CSR_ON_ANGLE,
                      {1'($urandom_range(1, 0)),
                       tpds_pkg::LIMIT_W'(touch + $urandom_range(3000, 0))});
            write_csr(tpds_pkg::CSR_LEVEL_TOL,
                      {1'($urandom_range(1, 0)), tpds_pkg::LIMIT_W'($urandom_range(1500, 0))});
            write_csr(tpds_pkg::CSR_POSITIVE_SIDE, 16'($urandom_range(65535, 0)));
            write_csr(CSR_UNUSED_INDEX, 16'($urandom_range(65535, 0)));
         end
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // every result back, then let the block settle
   task automatic wait_until_drained();
      while (accepted_count != queued_count || expected_status_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver: one transaction per handshake, random gaps
   always @(posedge clock) begin
      orient_cmd_type seen;
      orient_cmd_type next_cmd;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         // accepted at this edge, predict its status
         if (req_ch.valid && req_ch.ready) begin
            seen.command = req_ch.command;
            seen.roll    = req_ch.roll;
            seen.pitch   = req_ch.pitch;
            seen.yaw     = req_ch.yaw;
            predict_docking_step(seen);
            accepted_count++;
         end
         // bus free for a new transaction
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_cmd_q.size() != 0 && $urandom_range(99, 0) >= req_gap_pct) begin
               next_cmd       = pending_cmd_q.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.command <= next_cmd.command;
               req_ch.roll    <= next_cmd.roll;
               req_ch.pitch   <= next_cmd.pitch;
               req_ch.yaw     <= next_cmd.yaw;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long hold-off of the receiver, taken once on request
   always @(posedge clock) begin
      if (reset) begin
         stall_left  <= 0;
         stall_taken <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (stall_request && !stall_taken) begin
         stall_left  <= STALL_CYCLES;
         stall_taken <= 1'b1;
      end
   end

   // response ready with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (stall_left == 0) && ($urandom_range(99, 0) >= rsp_stall_pct);
      end
   end

   // status monitor: each accepted transaction against the oldest expectation
   always @(posedge clock) begin
      dock_status_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_status_q.size() == 0) begin
            report_mismatch("unexpected status transaction", rsp_ch.mode, 0);
         end else begin
            want = expected_status_q.pop_front();
            if (rsp_ch.mode !== want.mode) begin
               report_mismatch("mode", rsp_ch.mode, want.mode);
            end
            if (rsp_ch.drive_speed !== want.drive_speed) begin
               report_mismatch("drive_speed", rsp_ch.drive_speed, want.drive_speed);
            end
            if (rsp_ch.started !== want.started) begin
               report_mismatch("started", rsp_ch.started, want.started);
            end
         end
      end
   end

   // run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("FAILED: results differ");
      $finish;
   end

   // stimulus sequence
   initial begin
      // known values on every input from time zero
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.command = tpds_pkg::CMD_TICK;
      req_ch.roll    = '0;
      req_ch.pitch   = '0;
      req_ch.yaw     = '0;
      rsp_ch.ready   = 1'b0;
      stall_request  = 1'b0;
      queued_count   = 0;
      accepted_count = 0;
      mismatch_count = 0;
      req_gap_pct    = 33;
      rsp_stall_pct  = 81;

      // predictor at its reset state
      fill_sine_rom();
      gain_cfg     = tpds_pkg::RST_TILT_GAIN;
      approach_cfg = tpds_pkg::RST_APPROACH_SPEED;
      climb_cfg    = tpds_pkg::RST_CLIMB_SPEED;
      touch_cfg    = tpds_pkg::RST_TOUCH_ANGLE;
      on_cfg       = tpds_pkg::RST_ON_ANGLE;
      level_cfg    = tpds_pkg::RST_LEVEL_TOL;
      side_cfg     = 1'b1;
      dock_mode    = tpds_pkg::MODE_IDLE;
      held_speed   = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed walk through the whole sequence at reset settings
      queue_cmd(tpds_pkg::CMD_TICK, 32767, -32768, 0);         // tick while idle
      queue_cmd(CMD_UNUSED, -1, -1, -1);                      // unused code while idle
      queue_cmd(tpds_pkg::CMD_RESET, 0, 0, 0);                // reset while idle
      queue_cmd(tpds_pkg::CMD_START, 0, 0, 0);                // approach, speed still zero
      queue_cmd(tpds_pkg::CMD_START, 0, 0, 0);                // start outside idle ignored
      queue_cmd(tpds_pkg::CMD_TICK, 0, 0, 0);                 // level, approach speed
      queue_cmd(tpds_pkg::CMD_TICK, 0, -32768, 12868);        // steep tilt: touching
      queue_cmd(tpds_pkg::CMD_TICK, 5, -3, -32768);           // climb speed
      queue_cmd(tpds_pkg::CMD_TICK, -32768, 32767, -32768);   // on platform
      queue_cmd(tpds_pkg::CMD_TICK, 32767, 32767, 32767);     // balancing speed
      queue_cmd(tpds_pkg::CMD_TICK, 0, 0, 0);                 // level again: docked
      queue_cmd(tpds_pkg::CMD_TICK, -32768, -32768, 12868);   // tick while docked
      queue_cmd(tpds_pkg::CMD_START, 0, 0, 0);                // start while docked ignored
      queue_cmd(CMD_UNUSED, 0, 0, 0);                         // unused code while docked
      queue_cmd(tpds_pkg::CMD_RESET, 0, 0, 0);                // back to idle
      queue_cmd(tpds_pkg::CMD_START, 0, 0, 0);
      queue_cmd(tpds_pkg::CMD_TICK, 100, -100, -32768);       // held speed set in approach
      queue_cmd(tpds_pkg::CMD_RESET, 0, 0, 0);                // reset keeps held speed
      queue_cmd(tpds_pkg::CMD_START, 0, 0, 0);                // held speed shows again
      queue_cmd(CMD_UNUSED, 32767, 32767, 32767);             // unused code in approach
      wait_until_drained();

      // random docking traffic under changing settings and idling
      for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
         if (chunk < 2) begin
            req_gap_pct   = 33;
            rsp_stall_pct = 81;
         end else if (chunk < 4) begin
            req_gap_pct   = 81;
            rsp_stall_pct = 33;
         end else begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end
         apply_settings(chunk);
         queue_docking_traffic(CHUNK_ITEMS);
         // back pressure while the sender keeps offering
         if (chunk == 4) begin
            stall_request <= 1'b1;
         end
         wait_until_drained();
      end

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
